// ===== hdl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// shared widths, register indexes and stage types of the coulomb counter
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int TimeW    = 40;
  localparam int CurW     = 16;
  localparam int SumW     = CurW + 1;
  localparam int AccW     = 64;
  localparam int IntW     = 24;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = IntW;
  localparam int SplitW   = TimeW / 2;
  localparam int PartW    = SumW + SplitW + 1;
  localparam int ProdW    = PartW + SplitW;

  localparam logic [IntW-1:0] ResetInterval = IntW'(1100);

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE       = CfgIdxW'(0),
    REG_MIN_INTERVAL = CfgIdxW'(1)
  } tcc_reg_t;

  typedef struct packed {
    logic            enable;
    logic [IntW-1:0] min_interval_us;
  } tcc_cfg_t;

  typedef struct packed {
    logic                   sampled;
    logic                   report_current;
    logic signed [CurW-1:0] current_now;
  } tcc_ctl_t;

endpackage

// ===== hdl/tcc_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_gate
// input register, sample acceptance and current/time state
// ----------------------------------------------------------------------------
module tcc_gate (
  input  logic                                clk,
  input  logic                                rst,
  input  tcc_pkg::tcc_cfg_t                   cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcc_pkg::TimeW-1:0]           now_us,
  input  logic signed [tcc_pkg::CurW-1:0]     raw_current,
  input  logic                                read_ok,
  output logic                                s_valid,
  input  logic                                s_ready,
  output tcc_pkg::tcc_ctl_t                   s_ctl,
  output logic signed [tcc_pkg::SumW-1:0]     s_sum,
  output logic [tcc_pkg::TimeW-1:0]           s_dt
);

  logic                                hold_valid;
  logic [tcc_pkg::TimeW-1:0]           hold_now;
  logic signed [tcc_pkg::CurW-1:0]     hold_cur;
  logic                                hold_ok;

  logic [tcc_pkg::TimeW-1:0]           last_time;
  logic                                have_sample;
  logic signed [tcc_pkg::CurW-1:0]     prev_current;
  logic signed [tcc_pkg::CurW-1:0]     reported_current;
  logic                                have_reported;

  logic                                move;
  logic signed [tcc_pkg::TimeW:0]      dt;
  logic signed [tcc_pkg::TimeW:0]      min_gap;
  logic                                too_soon;
  logic                                accept;
  logic                                add_en;
  logic                                rep_cur;
  logic signed [tcc_pkg::SumW-1:0]     sum;
  tcc_pkg::tcc_ctl_t                   ctl_next;

  assign move     = hold_valid && (!s_valid || s_ready);
  assign in_ready = !hold_valid || move;

  assign dt       = $signed({1'b0, hold_now}) - $signed({1'b0, last_time});
  assign min_gap  = $signed({{(tcc_pkg::TimeW + 1 - tcc_pkg::IntW){1'b0}},
                             cfg.min_interval_us});
  assign too_soon = (last_time != '0) && (dt < min_gap);
  assign accept   = cfg.enable && hold_ok && !too_soon;
  assign add_en   = accept && have_sample && !dt[tcc_pkg::TimeW] && (dt != '0);
  assign rep_cur  = accept && (!have_reported || (hold_cur != reported_current));
  assign sum      = add_en ? ($signed({hold_cur[tcc_pkg::CurW-1], hold_cur})
                             + $signed({prev_current[tcc_pkg::CurW-1], prev_current}))
                           : '0;

  always_comb begin
    ctl_next.sampled        = accept;
    ctl_next.report_current = rep_cur;
    ctl_next.current_now    = accept ? hold_cur : prev_current;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid       <= 1'b0;
      s_valid          <= 1'b0;
      last_time        <= '0;
      have_sample      <= 1'b0;
      prev_current     <= '0;
      reported_current <= '0;
      have_reported    <= 1'b0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (!s_valid || s_ready) begin
        s_valid <= hold_valid;
      end
      if (move && accept) begin
        last_time    <= hold_now;
        have_sample  <= 1'b1;
        prev_current <= hold_cur;
      end
      if (move && rep_cur) begin
        reported_current <= hold_cur;
        have_reported    <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_now <= now_us;
      hold_cur <= raw_current;
      hold_ok  <= read_ok;
    end
    if (move) begin
      s_ctl <= ctl_next;
      s_sum <= sum;
      s_dt  <= dt[tcc_pkg::TimeW-1:0];
    end
  end

endmodule

// ===== hdl/tcc_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_mult
// two-stage product of current sum and elapsed time, split in halves
// ----------------------------------------------------------------------------
module tcc_mult (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                a_valid,
  output logic                                a_ready,
  input  tcc_pkg::tcc_ctl_t                   a_ctl,
  input  logic signed [tcc_pkg::SumW-1:0]     a_sum,
  input  logic [tcc_pkg::TimeW-1:0]           a_dt,
  output logic                                q_valid,
  input  logic                                q_ready,
  output tcc_pkg::tcc_ctl_t                   q_ctl,
  output logic signed [tcc_pkg::ProdW-1:0]    q_prod
);

  logic                                p_valid;
  tcc_pkg::tcc_ctl_t                   p_ctl;
  logic signed [tcc_pkg::PartW-1:0]    pp_lo;
  logic signed [tcc_pkg::PartW-1:0]    pp_hi;
  logic                                p_ready;
  logic signed [tcc_pkg::SplitW:0]     dt_lo;
  logic signed [tcc_pkg::SplitW:0]     dt_hi;
  logic signed [tcc_pkg::PartW-1:0]    lo_w;
  logic signed [tcc_pkg::PartW-1:0]    hi_w;
  logic signed [tcc_pkg::ProdW-1:0]    prod_w;

  assign p_ready = !q_valid || q_ready;
  assign a_ready = !p_valid || p_ready;

  assign dt_lo  = $signed({1'b0, a_dt[tcc_pkg::SplitW-1:0]});
  assign dt_hi  = $signed({1'b0, a_dt[tcc_pkg::TimeW-1:tcc_pkg::SplitW]});
  assign lo_w   = a_sum * dt_lo;
  assign hi_w   = a_sum * dt_hi;
  assign prod_w = $signed({pp_hi, {tcc_pkg::SplitW{1'b0}}})
                + $signed({{tcc_pkg::SplitW{pp_lo[tcc_pkg::PartW-1]}}, pp_lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        p_valid <= a_valid;
      end
      if (p_ready) begin
        q_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      p_ctl <= a_ctl;
      pp_lo <= lo_w;
      pp_hi <= hi_w;
    end
    if (p_valid && p_ready) begin
      q_ctl  <= p_ctl;
      q_prod <= prod_w;
    end
  end

endmodule

// ===== hdl/tcc_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_accum
// saturating charge accumulator and result register
// ----------------------------------------------------------------------------
module tcc_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  tcc_pkg::tcc_ctl_t                   q_ctl,
  input  logic signed [tcc_pkg::ProdW-1:0]    q_prod,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcc_pkg::tcc_ctl_t                   out_ctl,
  output logic signed [tcc_pkg::AccW-1:0]     out_total
);

  logic signed [tcc_pkg::AccW-1:0]     acc;
  logic signed [tcc_pkg::AccW-1:0]     acc_next;
  logic signed [tcc_pkg::AccW:0]       wide;
  logic                                load;

  assign q_ready = !out_valid || out_ready;
  assign load    = q_valid && q_ready;

  assign wide = $signed({acc[tcc_pkg::AccW-1], acc})
              + $signed({{(tcc_pkg::AccW + 1 - tcc_pkg::ProdW){q_prod[tcc_pkg::ProdW-1]}},
                         q_prod});

  always_comb begin
    if (wide[tcc_pkg::AccW] != wide[tcc_pkg::AccW-1]) begin
      acc_next = wide[tcc_pkg::AccW] ? {1'b1, {(tcc_pkg::AccW-1){1'b0}}}
                                     : {1'b0, {(tcc_pkg::AccW-1){1'b1}}};
    end else begin
      acc_next = wide[tcc_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (q_ready) begin
        out_valid <= q_valid;
      end
      if (load) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctl   <= q_ctl;
      out_total <= acc_next;
    end
  end

endmodule

// ===== hdl/trapezoid_coulomb_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_coulomb_counter
// trapezoidal integration of timestamped current samples into a saturating
// charge total
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_ready    | now_us, raw_current, read_ok
//  out     | out_valid / out_ready  | sampled, current_now, charge_total,
//          |                        | report_current, report_total
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one item per cycle sustained while out_ready stays high; each result passes:
//  input register, gate, two multiplier stages, accumulator/result register
//  acceptance state is updated in the gate stage so consecutive items chain
//  synchronous reset clears valid flags, gate state and accumulator; enable 0,
//  min interval 1100 us; each stage holds while the next is full, so a stalled
//  result backs up one stage at a time; cfg writes are always taken
// ----------------------------------------------------------------------------
module trapezoid_coulomb_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tcc_pkg::TimeW-1:0]            now_us,
  input  logic signed [tcc_pkg::CurW-1:0]      raw_current,
  input  logic                                 read_ok,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 sampled,
  output logic signed [tcc_pkg::CurW-1:0]      current_now,
  output logic signed [tcc_pkg::AccW-1:0]      charge_total,
  output logic                                 report_current,
  output logic                                 report_total,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [tcc_pkg::CfgDataW-1:0]         cfg_data
);

  tcc_pkg::tcc_cfg_t                   cfg;
  logic                                g_valid;
  logic                                g_ready;
  tcc_pkg::tcc_ctl_t                   g_ctl;
  logic signed [tcc_pkg::SumW-1:0]     g_sum;
  logic [tcc_pkg::TimeW-1:0]           g_dt;
  logic                                m_valid;
  logic                                m_ready;
  tcc_pkg::tcc_ctl_t                   m_ctl;
  logic signed [tcc_pkg::ProdW-1:0]    m_prod;
  tcc_pkg::tcc_ctl_t                   o_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.min_interval_us <= tcc_pkg::ResetInterval;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcc_pkg::REG_ENABLE:       cfg.enable          <= cfg_data[0];
        tcc_pkg::REG_MIN_INTERVAL: cfg.min_interval_us <= cfg_data[tcc_pkg::IntW-1:0];
        default: ;
      endcase
    end
  end

  tcc_gate u_gate (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .now_us      (now_us),
    .raw_current (raw_current),
    .read_ok     (read_ok),
    .s_valid     (g_valid),
    .s_ready     (g_ready),
    .s_ctl       (g_ctl),
    .s_sum       (g_sum),
    .s_dt        (g_dt)
  );

  tcc_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .a_valid (g_valid),
    .a_ready (g_ready),
    .a_ctl   (g_ctl),
    .a_sum   (g_sum),
    .a_dt    (g_dt),
    .q_valid (m_valid),
    .q_ready (m_ready),
    .q_ctl   (m_ctl),
    .q_prod  (m_prod)
  );

  tcc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (m_valid),
    .q_ready   (m_ready),
    .q_ctl     (m_ctl),
    .q_prod    (m_prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ctl   (o_ctl),
    .out_total (charge_total)
  );

  assign sampled        = o_ctl.sampled;
  assign current_now    = o_ctl.current_now;
  assign report_current = o_ctl.report_current;
  assign report_total   = o_ctl.sampled;

endmodule

// ===== hdl/tcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// port-level checks on the coulomb counter results
// ----------------------------------------------------------------------------
module tcc_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 sampled,
  input  logic signed [tcc_pkg::CurW-1:0]      current_now,
  input  logic signed [tcc_pkg::AccW-1:0]      charge_total,
  input  logic                                 report_current,
  input  logic                                 report_total
);

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a current report only comes with an accepted item
  a_report_needs_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_current |-> sampled)
    else $error("current reported on rejected item");

  a_total_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (report_total == sampled))
    else $error("report_total differs from sampled");

  // stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(charge_total)
      && $stable(current_now))
    else $error("stalled item changed");

endmodule

bind trapezoid_coulomb_counter tcc_checker u_tcc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .sampled        (sampled),
  .current_now    (current_now),
  .charge_total   (charge_total),
  .report_current (report_current),
  .report_total   (report_total)
);
